[design/trilinear_grid_attenuation_core_macros.svh]
// assertion macros used by the core design file
`ifndef TRILINEAR_GRID_ATTENUATION_CORE_MACROS_SVH
`define TRILINEAR_GRID_ATTENUATION_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define TGA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define TGA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/tga_pkg.sv]
// shared types, constants and the lerp function of the attenuation grid core
package tga_pkg;

  // field widths
  localparam int CoordW     = 6;   // holds a corner index for the largest grid
  localparam int IdxW       = 9;
  localparam int LightW     = 2;
  localparam int ValW       = 16;
  localparam int PointW     = 32;
  localparam int CfgW       = 32;
  localparam int CfgIdxW    = 3;

  // default sizes
  localparam int DefGridDim   = 8;
  localparam int DefNumLights = 4;

  localparam logic [ValW-1:0] OneQ15 = 16'h8000;
  localparam int RecipShift = 18;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_CPU_X     = 3'd3,
    REG_CPU_Y     = 3'd4,
    REG_CPU_Z     = 3'd5
  } cfg_reg_e;

  // per-axis mapping result
  typedef struct packed {
    logic [CoordW-1:0] lo;
    logic [CoordW-1:0] hi;
    logic [15:0]       w;
    logic              ok;
  } axis_t;

  // a*(1-w) + b*w rounded half up, Q1.15 values, Q0.16 weight
  function automatic logic [ValW-1:0] lerp(input logic [ValW-1:0] a,
                                           input logic [ValW-1:0] b,
                                           input logic [15:0] w);
    logic signed [16:0] dlt;
    logic signed [34:0] p;
    dlt = $signed({1'b0, b}) - $signed({1'b0, a});
    p = 35'(dlt) * 35'($signed({1'b0, w})) + 35'sd32768;
    return a + ValW'(p >>> 16);
  endfunction

endpackage

[design/trilinear_grid_attenuation_core.sv]
// Trilinear attenuation grid core: one cubic grid per light, cell writes and
// point queries on one stream. One word is accepted every cycle while the
// result register is free or being read; a query answers through the result
// register, a cell write gives no result. The grid sits in eight banks
// picked by the parity of the x, y and z cell index, each holding
// NUM_LIGHTS*ceil(GRID_DIM/2)^3 entries, so the eight corners of a query are
// read together; writes and reads meet the banks in the same pipeline
// stage, so a query always sees every write accepted before it.
module trilinear_grid_attenuation_core
  import tga_pkg::*;
#(
  parameter int GRID_DIM   = DefGridDim,
  parameter int NUM_LIGHTS = DefNumLights
) (
  input  logic                clk,
  input  logic                rst,
  // light_index, cell_index, cell_value, point_x, point_y, point_z, zero pad
  input  logic [127:0]        s_tdata,
  // command
  input  logic                s_tuser,
  input  logic                s_tvalid,
  output logic                s_tready,
  // attenuation_out
  output logic [15:0]         m_tdata,
  // inside_res
  output logic                m_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

`include "trilinear_grid_attenuation_core_macros.svh"

  localparam int Half      = (GRID_DIM + 1) / 2;
  localparam int BankDepth = NUM_LIGHTS * Half * Half * Half;
  localparam int AddrW     = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int Cells     = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int RecipQ    = ((1 << RecipShift) + GRID_DIM - 1) / GRID_DIM;

  // configuration registers
  logic [CfgW-1:0] box_min_x, box_min_y, box_min_z;
  logic [CfgW-1:0] cpu_x, cpu_y, cpu_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= '0;
      box_min_y <= '0;
      box_min_z <= '0;
      cpu_x     <= 32'd65536;
      cpu_y     <= 32'd65536;
      cpu_z     <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_MIN_X: box_min_x <= cfg_data;
        REG_BOX_MIN_Y: box_min_y <= cfg_data;
        REG_BOX_MIN_Z: box_min_z <= cfg_data;
        REG_CPU_X:     cpu_x     <= cfg_data;
        REG_CPU_Y:     cpu_y     <= cfg_data;
        REG_CPU_Z:     cpu_z     <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances when the result register is free or being read
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // valid and command chain
  logic [8:1] v;
  logic [8:1] cmd;

  logic [LightW-1:0] light1, light2, light3, light4, light5;
  logic [IdxW-1:0]   idx1, idx2, idx3;
  logic [ValW-1:0]   val1, val2, val3, val4, val5;
  logic [PointW-1:0] px1, py1, pz1;
  logic [IdxW-1:0]   q1_2, q1_3, zq3;
  logic [CoordW-1:0] x3, x4, x5, y4, y5;
  logic [IdxW-1:0]   z4, z5;
  logic              wok4, wok5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:1], s_tvalid};
    end
  end

  // input word and the write address decode
  always_ff @(posedge clk) begin
    if (en) begin
      cmd    <= {cmd[7:1], s_tuser};
      light1 <= s_tdata[1:0];
      idx1   <= s_tdata[10:2];
      val1   <= s_tdata[26:11];
      px1    <= s_tdata[58:27];
      py1    <= s_tdata[90:59];
      pz1    <= s_tdata[122:91];
      light2 <= light1;
      idx2   <= idx1;
      val2   <= val1;
      q1_2   <= IdxW'((32'(idx1) * 32'(RecipQ)) >> RecipShift);
      light3 <= light2;
      idx3   <= idx2;
      val3   <= val2;
      q1_3   <= q1_2;
      x3     <= CoordW'(32'(idx2) - 32'(q1_2) * 32'(GRID_DIM));
      zq3    <= IdxW'((32'(q1_2) * 32'(RecipQ)) >> RecipShift);
      light4 <= light3;
      x4     <= x3;
      y4     <= CoordW'(32'(q1_3) - 32'(zq3) * 32'(GRID_DIM));
      z4     <= zq3;
      wok4   <= (32'(light3) < 32'(NUM_LIGHTS)) && (32'(idx3) < 32'(Cells));
      val4   <= (val3 > OneQ15) ? OneQ15 : val3;
      light5 <= light4;
      x5     <= x4;
      y5     <= y4;
      z5     <= z4;
      wok5   <= wok4;
      val5   <= val4;
    end
  end

  // per-axis mapping, result lines up with stage five
  axis_t ax5, ay5, az5;

  tga_axis #(.GRID_DIM(GRID_DIM)) u_axis_x (
    .clk(clk), .en(en), .point(px1), .bmin(box_min_x), .scale(cpu_x), .res(ax5)
  );
  tga_axis #(.GRID_DIM(GRID_DIM)) u_axis_y (
    .clk(clk), .en(en), .point(py1), .bmin(box_min_y), .scale(cpu_y), .res(ay5)
  );
  tga_axis #(.GRID_DIM(GRID_DIM)) u_axis_z (
    .clk(clk), .en(en), .point(pz1), .bmin(box_min_z), .scale(cpu_z), .res(az5)
  );

  // bank addressing
  logic              light_ok5;
  logic [31:0]       lbase5;
  logic              wr_en;
  logic [2:0]        wr_bank;
  logic [AddrW-1:0]  wr_addr;
  logic [AddrW-1:0]  rd_addr [8];
  logic [ValW-1:0]   rd [8];

  assign light_ok5 = 32'(light5) < 32'(NUM_LIGHTS);
  assign lbase5    = light_ok5 ? 32'(light5) * 32'(BankDepth / NUM_LIGHTS) : 32'd0;
  assign wr_en     = en && v[5] && !cmd[5] && wok5;
  assign wr_bank   = {z5[0], y5[0], x5[0]};
  assign wr_addr   = AddrW'(lbase5 + 32'(x5 >> 1) + 32'(y5 >> 1) * 32'(Half)
                            + 32'(z5 >> 1) * 32'(Half * Half));

  for (genvar b = 0; b < 8; b++) begin : g_bank
    localparam logic [2:0] BankId = 3'(b);
    logic [ValW-1:0]   mem [BankDepth];
    logic [CoordW-1:0] cx, cy, cz;

    // pick the corner that falls in this parity bank
    assign cx = (ax5.lo[0] == BankId[0]) ? ax5.lo : ax5.hi;
    assign cy = (ay5.lo[0] == BankId[1]) ? ay5.lo : ay5.hi;
    assign cz = (az5.lo[0] == BankId[2]) ? az5.lo : az5.hi;
    assign rd_addr[b] = AddrW'(lbase5 + 32'(cx >> 1) + 32'(cy >> 1) * 32'(Half)
                               + 32'(cz >> 1) * 32'(Half * Half));

    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == BankId) begin
        mem[wr_addr] <= val5;
      end
      if (en) begin
        rd[b] <= mem[rd_addr[b]];
      end
    end
  end

  // corner parity and weights carried alongside the read
  logic       good6, good7, good8;
  logic [2:0] plo6, phi6;
  logic [15:0] wx6, wy6, wz6, wx7, wy7, wx8;

  always_ff @(posedge clk) begin
    if (en) begin
      good6 <= light_ok5 && ax5.ok && ay5.ok && az5.ok;
      plo6  <= {az5.lo[0], ay5.lo[0], ax5.lo[0]};
      phi6  <= {az5.hi[0], ay5.hi[0], ax5.hi[0]};
      wx6   <= ax5.w;
      wy6   <= ay5.w;
      wz6   <= az5.w;
    end
  end

  // bank holding the corner for a choice of lower or upper on each axis
  function automatic logic [2:0] bank_of(input logic hx, input logic hy, input logic hz,
                                         input logic [2:0] lo, input logic [2:0] hi);
    return {hz ? hi[2] : lo[2], hy ? hi[1] : lo[1], hx ? hi[0] : lo[0]};
  endfunction

  // four lerps in z, two in y, one in x
  logic [ValW-1:0] i1, i2, j1, j2, w1, w2;

  always_ff @(posedge clk) begin
    if (en) begin
      i1 <= lerp(rd[bank_of(1'b0, 1'b0, 1'b0, plo6, phi6)],
                 rd[bank_of(1'b0, 1'b0, 1'b1, plo6, phi6)], wz6);
      i2 <= lerp(rd[bank_of(1'b0, 1'b1, 1'b0, plo6, phi6)],
                 rd[bank_of(1'b0, 1'b1, 1'b1, plo6, phi6)], wz6);
      j1 <= lerp(rd[bank_of(1'b1, 1'b0, 1'b0, plo6, phi6)],
                 rd[bank_of(1'b1, 1'b0, 1'b1, plo6, phi6)], wz6);
      j2 <= lerp(rd[bank_of(1'b1, 1'b1, 1'b0, plo6, phi6)],
                 rd[bank_of(1'b1, 1'b1, 1'b1, plo6, phi6)], wz6);
      good7 <= good6;
      wy7   <= wy6;
      wx7   <= wx6;
      w1    <= lerp(i1, i2, wy7);
      w2    <= lerp(j1, j2, wy7);
      good8 <= good7;
      wx8   <= wx7;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v[8] && cmd[8];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= good8 ? lerp(w1, w2, wx8) : '0;
      m_tuser <= good8;
    end
  end

  `TGA_ASSERT_IMPL(a_outside_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == 16'd0)
  `TGA_ASSERT_IMPL(a_att_range, clk, rst, m_tvalid, m_tdata <= OneQ15)
  `TGA_ASSERT_NEXT(a_query_result, clk, rst, en && v[8] && cmd[8], m_tvalid)
  `TGA_ASSERT_NEXT(a_write_silent, clk, rst, en && !(v[8] && cmd[8]), !m_tvalid)

endmodule

[design/tga_axis.sv]
// maps one query coordinate into clamped corner indices and a weight
module tga_axis
  import tga_pkg::*;
#(
  parameter int GRID_DIM = DefGridDim
) (
  input  logic              clk,
  input  logic              en,
  input  logic [PointW-1:0] point,
  input  logic [CfgW-1:0]   bmin,
  input  logic [CfgW-1:0]   scale,
  output axis_t             res
);

  localparam logic [63:0] Limit = 64'(GRID_DIM) << 32;
  localparam logic [31:0] LastCell = 32'(GRID_DIM - 1);

  logic [31:0] mag;
  logic        neg2;
  logic [47:0] pl;
  logic [47:0] ph;
  logic        neg3;
  logic [63:0] c4;
  logic        neg4;

  logic signed [32:0] d;
  logic [47:0] c16;
  logic [47:0] t;
  logic [31:0] lof;
  logic        below;
  logic        clamp;
  axis_t       res_next;

  // distance from box minimum as sign and magnitude
  assign d = $signed({point[31], point}) - $signed({bmin[31], bmin});

  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= d[32];
      mag  <= d[32] ? 32'(-d) : 32'(d);
      neg3 <= neg2;
      pl   <= 48'(mag) * 48'(scale[15:0]);
      ph   <= 48'(mag) * 48'(scale[31:16]);
      neg4 <= neg3;
      c4   <= {16'b0, pl} + {ph, 16'b0};
      res  <= res_next;
    end
  end

  // margin test, half-cell shift and corner clamp
  always_comb begin
    c16   = neg4 ? 48'd0 : c4[63:16];
    below = c16 < 48'd32768;
    t     = c16 - 48'd32768;
    lof   = t[47:16];
    clamp = lof >= LastCell;
    res_next.ok = !((neg4 && c4 != 64'd0) || c4 > Limit);
    if (below) begin
      res_next.lo = '0;
      res_next.hi = '0;
      res_next.w  = '0;
    end else if (clamp) begin
      res_next.lo = CoordW'(LastCell);
      res_next.hi = CoordW'(LastCell);
      res_next.w  = '0;
    end else begin
      res_next.lo = CoordW'(lof);
      res_next.hi = CoordW'(lof + 32'd1);
      res_next.w  = t[15:0];
    end
  end

endmodule
